// ===== hw/rtl/u8u16_pkg.sv =====
// Shared constants for the UTF-8 to UTF-16 converter.
// Status codes, byte-class masks and surrogate constants.
// No dependencies.
`default_nettype none

package u8u16_pkg;

	// Result status codes
	typedef enum logic [2:0] {
		ST_ACCEPTED  = 3'd0,
		ST_ENDED     = 3'd1,
		ST_MALFORMED = 3'd2,
		ST_NO_ROOM   = 3'd3,
		ST_IGNORED   = 3'd4
	} status_t;

	// Configuration register indexes
	localparam logic REG_CAPACITY = 1'b0;

	localparam logic [15:0] CAPACITY_RESET = 16'd511;

	// UTF-8 byte classes
	localparam logic [7:0] CONT_MASK = 8'hC0;
	localparam logic [7:0] CONT_MARK = 8'h80;
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_MARK = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_MARK = 8'hE0;

	// UTF-16 surrogate construction
	localparam logic [15:0] HI_SURR = 16'hD800;
	localparam logic [15:0] LO_SURR = 16'hDC00;
	localparam logic [20:0] PLANE1  = 21'h10000;

	// Packed result item, first field in the highest bits
	typedef struct packed {
		logic [15:0] written;
		status_t     status;
		logic [1:0]  unit_count;
		logic [15:0] second_unit;
		logic [15:0] first_unit;
	} result_t;

	localparam int RESULT_W = $bits(result_t);
	localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

endpackage

`default_nettype wire

// ===== hw/rtl/utf8_to_utf16_converter.sv =====
// UTF-8 to UTF-16 converter top level: per-byte decode, string state,
// result register and APB capacity register. Depends on u8u16_pkg.
`default_nettype none

// Channel  | dir | handshake          | payload
// s_*      | in  | s_tvalid/s_tready  | s_tdata[7:0] byte_in
// m_*      | out | m_tvalid/m_tready  | m_tdata: first_unit, second_unit, unit_count,
//          |     |                    |   status, written (from bit 0 up), zero pad
// APB      | in  | psel/penable       | register 0 capacity at address 0
//
// One byte per cycle: each byte is decoded in the cycle it is taken and its
// result appears in the output register on the next cycle.
// The single output register sets the rate: a byte is taken whenever that
// register is empty or is being drained in the same cycle.
// Reset clears the string state and the output valid; capacity resets to 511.

module utf8_to_utf16_converter
	import u8u16_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// byte stream in
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [7:0]           s_tdata,   // [7:0] byte_in
	// unit stream out
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [TDATA_W-1:0]        m_tdata,   // first_unit, second_unit, unit_count,
	                                             // status, written; zero pad on top
	// configuration
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [2:0]           paddr,
	input  wire logic [31:0]          pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);

	logic [15:0] capacity_q;
	logic [20:0] code_q;
	logic [1:0]  pending_q;
	logic [15:0] total_q;
	logic        stopped_q;
	result_t     result_q;
	logic        out_valid_q;

	logic        in_acc;
	logic        reg_sel;

	// next-state and result of the byte at the input
	logic [20:0] code_d;
	logic [1:0]  pending_d;
	logic [15:0] total_d;
	logic        stopped_d;
	result_t     result_d;
	logic [20:0] code_fin;
	logic        finish;
	logic        need_two;
	logic [16:0] room;
	logic        no_room;
	logic [20:0] code_off;

	// APB
	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	always_comb begin
		prdata = 32'd0;
		if (reg_sel == REG_CAPACITY) begin
			prdata = {16'd0, capacity_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel == REG_CAPACITY) begin
			capacity_q <= pwdata[15:0];
		end
	end

	// handshake: output register drains while the next byte is taken
	assign s_tready = !out_valid_q || m_tready;
	assign in_acc   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(TDATA_W - RESULT_W){1'b0}}, result_q};

	// finishing check: surrogate pair for plane 1 and up, room test
	assign need_two = |code_fin[20:16];
	assign room     = {1'b0, capacity_q} - {1'b0, total_q};
	assign no_room  = room[16] || (room[15:0] == 16'd0) ||
	                  (need_two && room[15:0] == 16'd1);
	assign code_off = code_fin - PLANE1;

	// byte decode
	always_comb begin
		code_d    = code_q;
		pending_d = pending_q;
		total_d   = total_q;
		stopped_d = stopped_q;
		code_fin  = 21'd0;
		finish    = 1'b0;
		result_d  = '0;
		result_d.status = ST_ACCEPTED;

		if (stopped_q) begin
			result_d.status = ST_IGNORED;
			if (s_tdata == 8'd0) begin
				code_d    = 21'd0;
				pending_d = 2'd0;
				total_d   = 16'd0;
				stopped_d = 1'b0;
			end
		end else if (pending_q != 2'd0) begin
			if (s_tdata == 8'd0) begin
				result_d.status = ST_MALFORMED;
				code_d    = 21'd0;
				pending_d = 2'd0;
				total_d   = 16'd0;
			end else if ((s_tdata & CONT_MASK) != CONT_MARK) begin
				result_d.status = ST_MALFORMED;
				stopped_d = 1'b1;
				pending_d = 2'd0;
			end else begin
				code_fin  = {code_q[14:0], s_tdata[5:0]};
				code_d    = code_fin;
				pending_d = pending_q - 2'd1;
				finish    = (pending_q == 2'd1);
			end
		end else if (s_tdata == 8'd0) begin
			result_d.status     = ST_ENDED;
			result_d.unit_count = 2'd1;
			code_d    = 21'd0;
			total_d   = 16'd0;
		end else if (!s_tdata[7]) begin
			code_fin = {14'd0, s_tdata[6:0]};
			finish   = 1'b1;
		end else if ((s_tdata & LEAD2_MASK) == LEAD2_MARK) begin
			code_d    = {16'd0, s_tdata[4:0]};
			pending_d = 2'd1;
		end else if ((s_tdata & LEAD3_MASK) == LEAD3_MARK) begin
			code_d    = {17'd0, s_tdata[3:0]};
			pending_d = 2'd2;
		end else begin
			code_d    = {18'd0, s_tdata[2:0]};
			pending_d = 2'd3;
		end

		// emit units of a finished code point
		if (finish) begin
			code_d = 21'd0;
			if (no_room) begin
				result_d.status = ST_NO_ROOM;
				stopped_d = 1'b1;
			end else if (!need_two) begin
				result_d.first_unit = code_fin[15:0];
				result_d.unit_count = 2'd1;
				total_d = total_q + 16'd1;
			end else begin
				result_d.first_unit  = HI_SURR | {5'd0, code_off[20:10]};
				result_d.second_unit = LO_SURR | {6'd0, code_off[9:0]};
				result_d.unit_count  = 2'd2;
				total_d = total_q + 16'd2;
			end
		end

		// terminator reports the count before clearing
		if (!stopped_q && pending_q == 2'd0 && s_tdata == 8'd0) begin
			result_d.written = total_q;
		end else begin
			result_d.written = total_d;
		end
	end

	// string state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q    <= 21'd0;
			pending_q <= 2'd0;
			total_q   <= 16'd0;
			stopped_q <= 1'b0;
		end else if (in_acc) begin
			code_q    <= code_d;
			pending_q <= pending_d;
			total_q   <= total_d;
			stopped_q <= stopped_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			result_q <= result_d;
		end
	end

	// checks
	a_pend_not_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd0 |-> !stopped_q)
		else $error("continuation pending while stopped");

	a_stop_ignores: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && stopped_q |=> m_tvalid && result_q.status == ST_IGNORED &&
			result_q.unit_count == 2'd0)
		else $error("byte after stop was not ignored");

	a_pair_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && result_q.unit_count == 2'd2 |-> result_q.status == ST_ACCEPTED)
		else $error("pair emitted with a stop status");

	a_end_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && result_q.status == ST_ENDED |->
			result_q.unit_count == 2'd1 && result_q.first_unit == 16'd0)
		else $error("terminator malformed");

	a_acc_shows: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> m_tvalid)
		else $error("accepted byte produced no result");

endmodule

`default_nettype wire

// ===== test/utf8_to_utf16_converter_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for utf8_to_utf16_converter: mirrors the transcoder state for each
// accepted byte and checks every unit transaction field by field. Uses u8u16_pkg.

module utf8_to_utf16_converter_checker
	import u8u16_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	input  wire logic               s_tready,
	input  wire logic [7:0]         s_tdata,   // [7:0] byte_in
	input  wire logic               m_tvalid,
	input  wire logic               m_tready,
	input  wire logic [TDATA_W-1:0] m_tdata,   // first_unit, second_unit, unit_count,
	                                           // status, written; zero pad on top
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic               pready,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output int                      failures,
	output int                      outstanding
);

	localparam logic [2:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};

	// shadow of the capacity register and the per-string state
	logic [15:0] capacity;
	logic [20:0] code_point;
	logic [1:0]  cont_left;
	logic [15:0] units_written;
	logic        halted;
	result_t     expected_units[$];
	int          mismatches;

	function automatic void restart_string();
		code_point    = '0;
		cont_left     = '0;
		units_written = '0;
		halted        = 1'b0;
	endfunction

	// Advance the shadow state by one byte and return the unit transaction it causes
	function automatic result_t transcode_byte(input logic [7:0] b);
		result_t     r;
		logic        complete;
		logic [1:0]  need;
		logic [15:0] room;
		logic [20:0] offset;
		r        = '0;
		r.status = ST_ACCEPTED;
		complete = 1'b0;
		if (halted) begin
			// everything up to the next zero byte is dropped
			r.status = ST_IGNORED;
			if (b == 8'h00)
				restart_string();
		end else if (cont_left != 2'd0) begin
			if (b == 8'h00) begin
				r.status = ST_MALFORMED;
				restart_string();
			end else if ((b & CONT_MASK) != CONT_MARK) begin
				// bad continuation is not reused as a lead
				r.status  = ST_MALFORMED;
				halted    = 1'b1;
				cont_left = 2'd0;
			end else begin
				code_point = {code_point[14:0], b[5:0]};
				cont_left  = cont_left - 2'd1;
				complete   = (cont_left == 2'd0);
			end
		end else if (b == 8'h00) begin
			// terminator reports the count of the string it closes
			r.status     = ST_ENDED;
			r.unit_count = 2'd1;
			r.written    = units_written;
			restart_string();
			return r;
		end else if (!b[7]) begin
			code_point = {13'd0, b};
			complete   = 1'b1;
		end else if ((b & LEAD2_MASK) == LEAD2_MARK) begin
			code_point = {16'd0, b[4:0]};
			cont_left  = 2'd1;
		end else if ((b & LEAD3_MASK) == LEAD3_MARK) begin
			code_point = {17'd0, b[3:0]};
			cont_left  = 2'd2;
		end else begin
			// any other lead, stray continuations too, opens a 4-byte sequence
			code_point = {18'd0, b[2:0]};
			cont_left  = 2'd3;
		end

		if (complete) begin
			need = (code_point >= PLANE1) ? 2'd2 : 2'd1;
			room = (capacity > units_written) ? capacity - units_written : 16'd0;
			if (room < need) begin
				r.status = ST_NO_ROOM;
				halted   = 1'b1;
			end else if (need == 2'd1) begin
				r.first_unit  = code_point[15:0];
				r.unit_count  = 2'd1;
				units_written = units_written + 16'd1;
			end else begin
				offset        = code_point - PLANE1;
				r.first_unit  = HI_SURR | {5'd0, offset[20:10]};
				r.second_unit = LO_SURR | {6'd0, offset[9:0]};
				r.unit_count  = 2'd2;
				units_written = units_written + 16'd2;
			end
			code_point = '0;
		end
		r.written = units_written;
		return r;
	endfunction

	function automatic void check_field(input string name, input int unsigned want, got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	// Watch all three ports on each edge
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t got;
		if (!arst_n) begin
			capacity = CAPACITY_RESET;
			restart_string();
			expected_units.delete();
			mismatches = 0;
			failures    <= 0;
			outstanding <= 0;
		end else begin
			// results first: a byte taken at this edge has no result out yet
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata[RESULT_W-1:0]);
				if (expected_units.size() == 0) begin
					$error("unit transaction with nothing expected: tdata 0x%0h", m_tdata);
					mismatches++;
				end else begin
					want = expected_units.pop_front();
					check_field("first_unit", want.first_unit, got.first_unit);
					check_field("second_unit", want.second_unit, got.second_unit);
					check_field("unit_count", want.unit_count, got.unit_count);
					check_field("status", want.status, got.status);
					check_field("written", want.written, got.written);
					check_field("tdata pad", 0, m_tdata[TDATA_W-1:RESULT_W]);
				end
			end
			if (psel && penable && pwrite && pready && paddr == CAPACITY_ADDR)
				capacity = pwdata[15:0];
			if (s_tvalid && s_tready)
				expected_units.push_back(transcode_byte(s_tdata));
			failures    <= mismatches;
			outstanding <= expected_units.size();
		end
	end

endmodule

// ===== test/utf8_to_utf16_converter_tb.sv =====
`timescale 1ns / 100ps
// Top of the utf8_to_utf16_converter regression: clock, reset, byte and APB
// stimulus, random back-pressure and the verdict. Uses u8u16_pkg and the checker.

module utf8_to_utf16_converter_tb;
	import u8u16_pkg::*;

	localparam logic [2:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};
	localparam int IDLE_LIMIT   = 2000;
	localparam int PHASES       = 8;
	localparam int RANDOM_BYTES = 456;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [7:0]         s_tdata;
	logic               m_tvalid;
	logic               m_tready;
	logic [TDATA_W-1:0] m_tdata;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	int                 failures;
	int                 outstanding;
	// no-idle stretches for each side
	logic               send_steady;
	logic               recv_steady;
	int                 bytes_sent;

	utf8_to_utf16_converter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	utf8_to_utf16_converter_checker scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.failures    (failures),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int draw_wait(input logic steady);
		return steady ? 0 : int'($urandom_range(0, 15));
	endfunction

	// Sender: optional gap, then hold the byte until it is taken
	task automatic send_byte(input logic [7:0] value);
		int gap;
		gap = draw_wait(send_steady);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		bytes_sent++;
	endtask

	// Continuation bytes, now and then replaced by an arbitrary byte
	task automatic send_cont(input int count);
		repeat (count) begin
			if ($urandom_range(0, 19) == 0)
				send_byte(8'($urandom_range(0, 255)));
			else
				send_byte(CONT_MARK | 8'($urandom_range(0, 63)));
		end
	endtask

	// One string of mostly well-formed code points, closed by a zero byte
	task automatic send_random_string();
		int points;
		int kind;
		points = $urandom_range(0, 10);
		repeat (points) begin
			kind = $urandom_range(0, 9);
			if (kind == 0)
				send_byte(8'($urandom_range(0, 255)));
			else if (kind <= 3)
				send_byte(8'($urandom_range(1, 127)));
			else if (kind <= 5) begin
				send_byte(LEAD2_MARK | 8'($urandom_range(0, 31)));
				send_cont(1);
			end else if (kind <= 7) begin
				send_byte(LEAD3_MARK | 8'($urandom_range(0, 15)));
				send_cont(2);
			end else begin
				// 4-byte leads and stray continuations used as leads
				if ($urandom_range(0, 1) == 0)
					send_byte(8'hF0 | 8'($urandom_range(0, 15)));
				else
					send_byte(CONT_MARK | 8'($urandom_range(0, 63)));
				send_cont(3);
			end
		end
		send_byte(8'h00);
	endtask

	// Hold the sender until every pending unit transaction is out
	task automatic finish_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Receiver: random stall before each unit transaction
	initial begin
		int stall;
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			stall = draw_wait(recv_steady);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	// Watchdog on cycles with no transaction on any port
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		wait (arst_n);
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("utf8_to_utf16_converter regression: fail");
		$finish;
	end

	// Stimulus and verdict
	initial begin
		logic [7:0]  directed[$];
		logic [15:0] phase_caps[PHASES];
		int          phase_start;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		send_steady = 1'b0;
		recv_steady = 1'b0;
		bytes_sent  = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every sequence length, surrogate-range and oversized codes, then a
		// bad continuation, a zero in mid-sequence and a string left open
		directed = '{8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hED, 8'hA0, 8'h80,
			8'hF0, 8'h9F, 8'h98, 8'h80, 8'hFF, 8'hBF, 8'hBF, 8'hBF, 8'h7F, 8'h00,
			8'hC3, 8'h41, 8'h00, 8'hE2, 8'h00, 8'h41, 8'h41};
		foreach (directed[i]) send_byte(directed[i]);

		// capacity dropped under the open string, then a pair with one unit of room
		finish_results();
		apb_write(CAPACITY_ADDR, 32'd1);
		directed = '{8'h41, 8'h00, 8'hF0, 8'h90, 8'h80, 8'h80, 8'h00};
		foreach (directed[i]) send_byte(directed[i]);

		// random strings under a range of capacities, extremes included
		phase_caps = '{16'd0, 16'hFFFF, 16'd2, 16'd3, 16'($urandom_range(4, 12)),
			16'($urandom_range(0, 65535)), 16'd1, CAPACITY_RESET};
		for (int p = 0; p < PHASES; p++) begin
			finish_results();
			apb_write(CAPACITY_ADDR, {16'd0, phase_caps[p]});
			send_steady = ($urandom_range(0, 3) == 0);
			recv_steady = ($urandom_range(0, 3) == 0);
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < RANDOM_BYTES / PHASES) begin
				send_random_string();
				if ($urandom_range(0, 19) == 0)
					finish_results();
			end
		end

		finish_results();
		repeat (4) @(posedge clk);
		if (failures == 0)
			$display("utf8_to_utf16_converter regression: pass");
		else
			$display("utf8_to_utf16_converter regression: fail");
		$finish;
	end

endmodule
